@@ hdl/hsvoa_pkg.sv @@
// Shared types and register codes for the HSV offset pixel adjust block.
`default_nettype none
package hsvoa_pkg;

  typedef struct packed {
    logic adv;
    logic vld;
  } pipe_ctl_t;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 18;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HUE_OFFSET,
    CFG_SAT_OFFSET,
    CFG_VAL_OFFSET
  } cfg_idx_e;

endpackage
`default_nettype wire

@@ hdl/hsv_offset_pixel_adjust_core.sv @@
// Top level: RGB to HSV, offset and clamp, HSV back to RGB, fully pipelined.
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+------------------------------
//  in       | sink      | in_valid_i / in_stall_o    | in_red_i in_green_i in_blue_i
//  out      | source    | out_valid_o / out_stall_i  | out_red_o out_green_o out_blue_o
//  cfg      | sink      | cfg_valid_i / cfg_ready_o  | cfg_index_i cfg_data_i
//
// One item per cycle while the output is not stalled; the hue and saturation divider
// pipelines retire four quotient bits a stage.
// Reset clears all valid bits and the three offsets.
// A stalled result at the output freezes every stage; in_stall_o follows it.
`default_nettype none
module hsv_offset_pixel_adjust_core #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  wire                                      clk_i,
  input  wire                                      rst_ni,
  input  wire                                      in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [7:0]                          in_red_i,
  input  wire logic [7:0]                          in_green_i,
  input  wire logic [7:0]                          in_blue_i,
  output logic                                     out_valid_o,
  input  wire                                      out_stall_i,
  output logic [7:0]                               out_red_o,
  output logic [7:0]                               out_green_o,
  output logic [7:0]                               out_blue_o,
  input  wire                                      cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [hsvoa_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [hsvoa_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import hsvoa_pkg::*;

  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned HW  = 9 + F;
  localparam int unsigned SW  = 7 + F;
  localparam int unsigned RW  = 6 + F;
  localparam int unsigned NH  = 17 + F;
  localparam int unsigned NV  = 15 + F;
  localparam int unsigned VBW = 8 + F;
  localparam int unsigned TW  = 7 + 2 * F;
  localparam int unsigned PAW = 15 + 2 * F;
  localparam int unsigned TL  = (TW + 1) / 2;
  localparam int unsigned PBW = VBW + TW;
  localparam int unsigned OW  = 20 + F;
  localparam int unsigned SPS = 4;
  localparam int unsigned SHL = (F >= 8) ? F - 8 : 0;
  localparam int unsigned SHR = (F < 8) ? 8 - F : 0;
  localparam int unsigned KV  = NV + 8;
  localparam int unsigned VPW = KV + 8;
  localparam int unsigned KB  = NV + 7;
  localparam int unsigned KF  = RW + 6;
  localparam int unsigned MBW = NV + 1;
  localparam int unsigned MFW = RW + 1;
  localparam int unsigned BPW = 2 * NV + 1;
  localparam int unsigned FPW = 2 * RW + 1;

  localparam logic [63:0] MV64 = ((64'd1 << KV) + 64'd254) / 64'd255;
  localparam logic [63:0] MB64 = ((64'd1 << KB) + 64'd99) / 64'd100;
  localparam logic [63:0] MF64 = ((64'd1 << KF) + 64'd59) / 64'd60;
  localparam logic [KV-1:0]  CV = KV'(64'd100 * MV64);
  localparam logic [MBW-1:0] MB = MBW'(MB64);
  localparam logic [MFW-1:0] MF = MFW'(MF64);

  localparam logic [HW-1:0] HUE_MAX = HW'(360) << F;
  localparam logic [HW-1:0] SAT_MAX = HW'(100) << F;
  localparam logic [HW-1:0] SEC_LEN = HW'(60) << F;
  localparam logic [SW-1:0] D_FULL  = SW'(100) << F;
  localparam logic [TW-1:0] DF_FULL = TW'(100) << (2 * F);
  localparam logic [F:0]    ONE     = (F + 1)'(1) << F;

  function automatic logic [HW-1:0] clampv(input logic [OW-1:0] x, input logic [HW-1:0] hi);
    logic [HW-1:0] r;
    if (x[OW-1]) r = '0;
    else if (x > OW'(hi)) r = hi;
    else r = x[HW-1:0];
    return r;
  endfunction

  function automatic logic [7:0] recip100(input logic [14:0] x);
    logic [27:0] p;
    p = 28'(x) * 28'd5243;
    return p[26:19];
  endfunction

  logic adv;
  pipe_ctl_t ctl1;

  // configuration
  logic signed [17:0] hue_off_q;
  logic signed [15:0] sat_off_q, val_off_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_off_q <= '0;
      sat_off_q <= '0;
      val_off_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_HUE_OFFSET: hue_off_q <= $signed(cfg_data_i);
        CFG_SAT_OFFSET: sat_off_q <= $signed(cfg_data_i[15:0]);
        CFG_VAL_OFFSET: val_off_q <= $signed(cfg_data_i[15:0]);
        default: ;
      endcase
    end
  end

  // valid bits
  logic v0_q, v1_q, v2_q, v3_q, vm_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q;
  logic v_div1;

  assign adv        = !v9_q || !out_stall_i;
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0; v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; vm_q <= 1'b0;
      v4_q <= 1'b0; v5_q <= 1'b0; v6_q <= 1'b0; v7_q <= 1'b0; v8_q <= 1'b0;
      v9_q <= 1'b0;
    end else if (adv) begin
      v0_q <= in_valid_i;
      v1_q <= v0_q;
      v2_q <= v_div1;
      v3_q <= v2_q;
      vm_q <= v3_q;
      v4_q <= vm_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= v7_q;
      v9_q <= v8_q;
    end
  end

  // stage 0: input register
  logic [7:0] r0_q, g0_q, b0_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r0_q <= in_red_i;
      g0_q <= in_green_i;
      b0_q <= in_blue_i;
    end
  end

  // stage 1: max, min, hue numerator, divider operands, scaled value
  logic [7:0]     mx_s, mn_s, dif_s;
  logic [16:0]    num_s;
  logic [NH-1:0]  hdvd_q, sdvd_q;
  logic [7:0]     hdvs_q, sdvs_q;
  logic [VPW-1:0] vprd_q;

  always_comb begin
    mx_s = r0_q;
    if (g0_q > mx_s) mx_s = g0_q;
    if (b0_q > mx_s) mx_s = b0_q;
    mn_s = r0_q;
    if (g0_q < mn_s) mn_s = g0_q;
    if (b0_q < mn_s) mn_s = b0_q;
    dif_s = mx_s - mn_s;
    if (b0_q == mx_s) begin
      num_s = 17'd240 * 17'(dif_s) + 17'd60 * 17'(r0_q) - 17'd60 * 17'(g0_q);
    end else if (g0_q == mx_s) begin
      num_s = 17'd120 * 17'(dif_s) + 17'd60 * 17'(b0_q) - 17'd60 * 17'(r0_q);
    end else if (g0_q >= b0_q) begin
      num_s = 17'd60 * 17'(g0_q) - 17'd60 * 17'(b0_q);
    end else begin
      num_s = 17'd360 * 17'(dif_s) + 17'd60 * 17'(g0_q) - 17'd60 * 17'(b0_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hdvd_q <= (dif_s == 8'd0) ? '0 : {num_s, {F{1'b0}}};
      hdvs_q <= (dif_s == 8'd0) ? 8'd1 : dif_s;
      sdvd_q <= NH'({15'(dif_s) * 15'd100, {F{1'b0}}});
      sdvs_q <= (mx_s == 8'd0) ? 8'd1 : mx_s;
      vprd_q <= VPW'(mx_s) * VPW'(CV);
    end
  end

  assign ctl1.adv = adv;
  assign ctl1.vld = v1_q;

  logic [NH-1:0] hq, sq;
  logic [SW-1:0] vq;

  hsvoa_div #(.NW(NH), .DW(8), .SPS(SPS), .PW(SW)) u_div_hue (
    .clk_i, .rst_ni, .ctl_i(ctl1), .dvd_i(hdvd_q), .dvs_i(hdvs_q),
    .side_i(vprd_q[KV-F +: SW]), .vld_o(v_div1), .quo_o(hq), .side_o(vq)
  );

  hsvoa_div #(.NW(NH), .DW(8), .SPS(SPS), .PW(1)) u_div_sat (
    .clk_i, .rst_ni, .ctl_i(ctl1), .dvd_i(sdvd_q), .dvs_i(sdvs_q), .side_i(1'b0),
    .vld_o(), .quo_o(sq), .side_o()
  );

  // stage 2: add offsets and clamp
  logic signed [OW-1:0] hoff_s, soff_s, voff_s, hsum_s, ssum_s, vsum_s;
  logic [HW-1:0] hue2_q;
  logic [SW-1:0] sat2_q, val2_q;

  always_comb begin
    hoff_s = (OW'(hue_off_q) <<< SHL) >>> SHR;
    soff_s = (OW'(sat_off_q) <<< SHL) >>> SHR;
    voff_s = (OW'(val_off_q) <<< SHL) >>> SHR;
    hsum_s = $signed(OW'(hq[HW-1:0])) + hoff_s;
    ssum_s = $signed(OW'(sq[SW-1:0])) + soff_s;
    vsum_s = $signed(OW'(vq)) + voff_s;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hue2_q <= clampv(hsum_s, HUE_MAX);
      sat2_q <= SW'(clampv(ssum_s, SAT_MAX));
      val2_q <= SW'(clampv(vsum_s, SAT_MAX));
    end
  end

  // stage 3: sector, remainder in sector, scaled value
  logic [2:0]    sec_s;
  logic [HW-1:0] base_s;
  logic [RW-1:0] rem_s;
  logic [NV-1:0] vbn3_q;
  logic [RW-1:0] rem3_q;
  logic [SW-1:0] sat3_q;
  logic [2:0]    sec3_q;

  always_comb begin
    sec_s = 3'd0;
    for (int k = 1; k <= 6; k++) begin
      if (hue2_q >= HW'(k) * SEC_LEN) sec_s = 3'(k);
    end
    base_s = HW'(sec_s) * SEC_LEN;
    rem_s  = RW'(hue2_q - base_s);
    if (sec_s == 3'd6) begin
      sec_s = 3'd0;
      rem_s = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vbn3_q <= NV'(val2_q) * NV'(255);
      rem3_q <= rem_s;
      sat3_q <= sat2_q;
      sec3_q <= sec_s;
    end
  end

  // multiply by reciprocals of one hundred and of sixty
  logic [BPW-1:0] vbp_q;
  logic [FPW-1:0] fp_q;
  logic [SW-1:0]  satm_q;
  logic [2:0]     secm_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vbp_q  <= BPW'(vbn3_q) * BPW'(MB);
      fp_q   <= FPW'(rem3_q) * FPW'(MF);
      satm_q <= sat3_q;
      secm_q <= sec3_q;
    end
  end

  // stage 4: products with saturation
  logic [VBW-1:0] vb_s;
  logic [F-1:0]   f_s;
  logic [F:0]     omf_s;
  logic [SW-1:0]  sat4_s;
  logic [PAW-1:0] pa4_q;
  logic [TW-1:0]  sf4_q, sg4_q;
  logic [VBW-1:0] vb4_q, vb5_q;
  logic [2:0]     sec4_q, sec5_q, sec6_q, sec7_q, sec8_q;

  assign vb_s   = vbp_q[KB +: VBW];
  assign f_s    = fp_q[KF +: F];
  assign omf_s  = ONE - (F + 1)'(f_s);
  assign sat4_s = satm_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pa4_q  <= PAW'(vb_s) * PAW'(D_FULL - sat4_s);
      sf4_q  <= TW'(sat4_s) * TW'(f_s);
      sg4_q  <= TW'(sat4_s) * TW'(omf_s);
      vb4_q  <= vb_s;
      sec4_q <= secm_q;
    end
  end

  // stage 5: interpolation terms
  logic [TW-1:0] tb5_q, tc5_q;
  logic [14:0]   xa5_q, xa6_q, xa7_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tb5_q  <= DF_FULL - sf4_q;
      tc5_q  <= DF_FULL - sg4_q;
      xa5_q  <= pa4_q[PAW-1:2*F];
      vb5_q  <= vb4_q;
      sec5_q <= sec4_q;
    end
  end

  // stage 6: partial products
  logic [PBW-1:0] pbl6_q, pbh6_q, pcl6_q, pch6_q;
  logic [7:0]     vv6_q, vv7_q, vv8_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pbl6_q <= PBW'(vb5_q) * PBW'(tb5_q[TL-1:0]);
      pbh6_q <= PBW'(vb5_q) * PBW'(tb5_q[TW-1:TL]);
      pcl6_q <= PBW'(vb5_q) * PBW'(tc5_q[TL-1:0]);
      pch6_q <= PBW'(vb5_q) * PBW'(tc5_q[TW-1:TL]);
      xa6_q  <= xa5_q;
      vv6_q  <= vb5_q[VBW-1:F];
      sec6_q <= sec5_q;
    end
  end

  // stage 7: sum partial products
  logic [PBW-1:0] fb_s, fc_s;
  logic [14:0]    xb7_q, xc7_q;

  assign fb_s = (pbh6_q << TL) + pbl6_q;
  assign fc_s = (pch6_q << TL) + pcl6_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      xb7_q  <= fb_s[PBW-1:3*F];
      xc7_q  <= fc_s[PBW-1:3*F];
      xa7_q  <= xa6_q;
      vv7_q  <= vv6_q;
      sec7_q <= sec6_q;
    end
  end

  // stage 8: divide by one hundred
  logic [7:0] a8_q, b8_q, c8_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a8_q   <= recip100(xa7_q);
      b8_q   <= recip100(xb7_q);
      c8_q   <= recip100(xc7_q);
      vv8_q  <= vv7_q;
      sec8_q <= sec7_q;
    end
  end

  // stage 9: sector select into output register
  logic [7:0] ro_d, go_d, bo_d;

  always_comb begin
    case (sec8_q)
      3'd0:    begin ro_d = vv8_q; go_d = c8_q;  bo_d = a8_q;  end
      3'd1:    begin ro_d = b8_q;  go_d = vv8_q; bo_d = a8_q;  end
      3'd2:    begin ro_d = a8_q;  go_d = vv8_q; bo_d = c8_q;  end
      3'd3:    begin ro_d = a8_q;  go_d = b8_q;  bo_d = vv8_q; end
      3'd4:    begin ro_d = c8_q;  go_d = a8_q;  bo_d = vv8_q; end
      default: begin ro_d = vv8_q; go_d = a8_q;  bo_d = b8_q;  end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_red_o   <= ro_d;
      out_green_o <= go_d;
      out_blue_o  <= bo_d;
    end
  end

  assign out_valid_o = v9_q;

`ifndef SYNTHESIS
  a_stall_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("output stalled but input not stalled");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v0_q)
    else $error("accepted item missing from first stage");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> ($stable(v8_q) && $stable(sec8_q)))
    else $error("pipeline moved while stalled");
`endif

endmodule
`default_nettype wire

@@ hdl/hsvoa_div.sv @@
// Pipelined restoring divider, SPS quotient bits per register stage.
`default_nettype none
module hsvoa_div #(
  parameter int unsigned NW  = 25,
  parameter int unsigned DW  = 8,
  parameter int unsigned SPS = 4,
  parameter int unsigned PW  = 1
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  hsvoa_pkg::pipe_ctl_t     ctl_i,
  input  wire logic [NW-1:0]       dvd_i,
  input  wire logic [DW-1:0]       dvs_i,
  input  wire logic [PW-1:0]       side_i,
  output logic                     vld_o,
  output logic [NW-1:0]            quo_o,
  output logic [PW-1:0]            side_o
);
  import hsvoa_pkg::*;

  localparam int unsigned NST = (NW + SPS - 1) / SPS;

  logic          vld_q  [NST];
  logic [DW-1:0] rem_q  [NST];
  logic [NW-1:0] wrk_q  [NST];
  logic [DW-1:0] dvs_q  [NST];
  logic [PW-1:0] side_q [NST];

  for (genvar s = 0; s < NST; s++) begin : g_stg
    logic          vld_in;
    logic [DW-1:0] rem_in;
    logic [NW-1:0] wrk_in;
    logic [DW-1:0] dvs_in;
    logic [PW-1:0] side_in;
    logic [DW-1:0] rem_d;
    logic [NW-1:0] wrk_d;

    if (s == 0) begin : g_first
      assign vld_in  = ctl_i.vld;
      assign rem_in  = '0;
      assign wrk_in  = dvd_i;
      assign dvs_in  = dvs_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign wrk_in  = wrk_q[s-1];
      assign dvs_in  = dvs_q[s-1];
      assign side_in = side_q[s-1];
    end

    always_comb begin
      logic [DW:0] acc;
      rem_d = rem_in;
      wrk_d = wrk_in;
      acc   = '0;
      for (int k = 0; k < SPS; k++) begin
        if (s * SPS + k < NW) begin
          acc   = {rem_d, wrk_d[NW-1]};
          wrk_d = {wrk_d[NW-2:0], 1'b0};
          if (acc >= {1'b0, dvs_in}) begin
            acc      = acc - {1'b0, dvs_in};
            wrk_d[0] = 1'b1;
          end
          rem_d = acc[DW-1:0];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (ctl_i.adv) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.adv) begin
        rem_q[s]  <= rem_d;
        wrk_q[s]  <= wrk_d;
        dvs_q[s]  <= dvs_in;
        side_q[s] <= side_in;
      end
    end
  end

  assign vld_o  = vld_q[NST-1];
  assign quo_o  = wrk_q[NST-1];
  assign side_o = side_q[NST-1];

endmodule
`default_nettype wire
